FILE: rtl/ler_pkg.sv
// Package for the light effect range block: item types, controller states,
// datapath command and status structs, probe ladder table.
// No dependencies.
package ler_pkg;

  localparam int DIST_W = 16;

  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

  localparam logic [2:0] KIND_POINT  = 3'd0;
  localparam logic [2:0] KIND_SPOT   = 3'd1;
  localparam logic [2:0] KIND_BOX    = 3'd2;
  localparam logic [2:0] KIND_SPHERE = 3'd3;

  localparam logic [2:0] PROBE_FIRST = 3'd0;
  localparam logic [2:0] PROBE_LAST  = 3'd6;

  localparam logic [4:0] SQ_LAST   = 5'd3;
  localparam logic [4:0] ROOT_LAST = 5'd31;

  typedef struct packed {
    logic [2:0]         light_kind;
    logic signed [31:0] constant_term;
    logic signed [31:0] linear_term;
    logic signed [31:0] quadratic_term;
    logic signed [31:0] light_intensity;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] range_value;
    logic               range_infinite;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_EV_MUL1,
    ST_EV_MUL2,
    ST_EV_ADD,
    ST_EV_DECIDE,
    ST_CHECK,
    ST_SQ,
    ST_ROOT_INIT,
    ST_ROOT,
    ST_ROOT_FIN,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    MUL_Q_DD,
    MUL_C,
    MUL_L,
    MUL_Q
  } mul_sel_e;

  typedef enum logic [1:0] {
    FIN_DIST,
    FIN_SQRT,
    FIN_CONST,
    FIN_INF
  } fin_sel_e;

  typedef struct packed {
    logic              in_load;
    logic              d_load;
    logic              d_inc;
    logic [DIST_W-1:0] d_value;
    logic              ev_mul1;
    logic              mul_en;
    mul_sel_e          mul_sel;
    logic              s1_en;
    logic              a_en;
    logic              acc_clr;
    logic              acc_en;
    logic              root_init;
    logic              root_step;
    logic              fin_load;
    fin_sel_e          fin_sel;
    logic              out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       cmp_below;
    logic       cmp_above;
    logic       d_at_max;
  } stat_t;

  // probe ladder: distance tried at each rung
  function automatic logic [DIST_W-1:0] probe_dist(input logic [2:0] idx);
    logic [DIST_W-1:0] r;
    unique case (idx)
      3'd0:    r = DIST_W'(1000);
      3'd1:    r = DIST_W'(20);
      3'd2:    r = DIST_W'(750);
      3'd3:    r = DIST_W'(50);
      3'd4:    r = DIST_W'(100);
      3'd5:    r = DIST_W'(500);
      3'd6:    r = DIST_W'(250);
      default: r = '0;
    endcase
    return r;
  endfunction

  // search start taken when the rung hits
  function automatic logic [DIST_W-1:0] probe_start(input logic [2:0] idx);
    logic [DIST_W-1:0] r;
    unique case (idx)
      3'd2:    r = DIST_W'(750);
      3'd3:    r = DIST_W'(21);
      3'd4:    r = DIST_W'(51);
      3'd5:    r = DIST_W'(500);
      3'd6:    r = DIST_W'(250);
      default: r = '0;
    endcase
    return r;
  endfunction

  // 1: rung hits when below threshold, 0: when above
  function automatic logic probe_on_below(input logic [2:0] idx);
    logic r;
    unique case (idx)
      3'd1, 3'd3, 3'd4: r = 1'b1;
      default:          r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/ler_dp.sv
// Datapath of the light effect range block: item capture, attenuation
// evaluation pipeline, squared-sum accumulator, bit-pair square root, result regs.
// Depends on ler_pkg; driven by ler_ctrl through ler_pkg::cmd_t.
module ler_dp #(
  parameter int MAX_DISTANCE  = 1000,
  parameter int FRACTION_BITS = 16
) (
  input  logic              clk_i,
  input  ler_pkg::in_item_t in_data_i,
  input  ler_pkg::cmd_t     cmd_i,
  output ler_pkg::stat_t    stat_o,
  output ler_pkg::out_item_t out_data_o
);

  localparam logic [ler_pkg::DIST_W-1:0] MaxDist = ler_pkg::DIST_W'(MAX_DISTANCE);
  localparam logic [63:0] QuadLimit = 64'h2000_0000_0000_0000;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic [31:0] sat_pos(input logic [63:0] v);
    return (v > 64'(ler_pkg::POS_MAX)) ? ler_pkg::POS_MAX : v[31:0];
  endfunction

  // captured item
  logic [2:0]         kind_q;
  logic signed [31:0] c_q;
  logic signed [31:0] l_q;
  logic [31:0]        cmag_q, lmag_q, qmag_q;
  logic               qneg_q;
  logic [39:0]        lim_q;
  logic [31:0]        imag;

  // evaluation pipeline
  logic [ler_pkg::DIST_W-1:0] d_q;
  logic signed [ler_pkg::DIST_W:0] d_s;
  logic [31:0]        dd_q;
  logic signed [48:0] ld_d, ld_q;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mulp_q;
  logic [63:0]        pc;
  logic signed [63:0] s1_q, a_q;
  logic [63:0]        a_u;
  logic               a_pos;

  // square root
  logic [63:0] acc_q, rem_q, res_q, bit_q, root_t;
  logic [63:0] rnd;
  logic [63:0] dist_sh;

  ler_pkg::out_item_t fin_d, fin_q, out_q;

  assign imag = mag32(in_data_i.light_intensity);

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      kind_q <= in_data_i.light_kind;
      c_q    <= in_data_i.constant_term;
      l_q    <= in_data_i.linear_term;
      cmag_q <= mag32(in_data_i.constant_term);
      lmag_q <= mag32(in_data_i.linear_term);
      qmag_q <= mag32(in_data_i.quadratic_term);
      qneg_q <= in_data_i.quadratic_term[31];
      lim_q  <= {imag, 8'b0} - 40'(imag);  // 255 * |intensity|
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.d_load) begin
      d_q <= cmd_i.d_value;
    end else if (cmd_i.d_inc) begin
      d_q <= d_q + ler_pkg::DIST_W'(1);
    end
  end

  assign d_s  = {1'b0, d_q};
  assign ld_d = 49'(l_q) * 49'(d_s);

  always_ff @(posedge clk_i) begin
    if (cmd_i.ev_mul1) begin
      dd_q <= 32'(d_q) * 32'(d_q);
      ld_q <= ld_d;
    end
  end

  always_comb begin
    unique case (cmd_i.mul_sel)
      ler_pkg::MUL_Q_DD: begin
        mul_a = qmag_q;
        mul_b = dd_q;
      end
      ler_pkg::MUL_C: begin
        mul_a = cmag_q;
        mul_b = cmag_q;
      end
      ler_pkg::MUL_L: begin
        mul_a = lmag_q;
        mul_b = lmag_q;
      end
      ler_pkg::MUL_Q: begin
        mul_a = qmag_q;
        mul_b = qmag_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      mulp_q <= 64'(mul_a) * 64'(mul_b);
    end
    if (cmd_i.s1_en) begin
      s1_q <= 64'(c_q) + 64'(ld_q);
    end
  end

  // quadratic term clamped to 2^61
  assign pc = (mulp_q > QuadLimit) ? QuadLimit : mulp_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.a_en) begin
      a_q <= qneg_q ? (s1_q - signed'(pc)) : (s1_q + signed'(pc));
    end
  end

  assign a_u   = a_q;
  assign a_pos = !a_q[63] && (a_q != 64'sd0);

  // zero attenuation counts as infinitely bright
  assign stat_o.kind      = kind_q;
  assign stat_o.cmp_below = a_q[63] || (a_pos && (64'(lim_q) < a_u));
  assign stat_o.cmp_above = (a_q == 64'sd0) || (a_pos && (64'(lim_q) > a_u));
  assign stat_o.d_at_max  = (d_q >= MaxDist);

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_en) begin
      acc_q <= acc_q + mulp_q;
    end
  end

  assign root_t = res_q + bit_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.root_init) begin
      rem_q <= acc_q;
      res_q <= '0;
      bit_q <= 64'h4000_0000_0000_0000;
    end else if (cmd_i.root_step) begin
      if (rem_q >= root_t) begin
        rem_q <= rem_q - root_t;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  // rem holds s - res^2 after the last step; round up past the midpoint
  assign rnd     = res_q + 64'(rem_q > res_q);
  assign dist_sh = 64'(d_q) << FRACTION_BITS;

  always_comb begin
    unique case (cmd_i.fin_sel)
      ler_pkg::FIN_DIST: begin
        fin_d.range_value    = sat_pos(dist_sh);
        fin_d.range_infinite = 1'b0;
      end
      ler_pkg::FIN_SQRT: begin
        fin_d.range_value    = sat_pos(rnd);
        fin_d.range_infinite = 1'b0;
      end
      ler_pkg::FIN_CONST: begin
        fin_d.range_value    = c_q;
        fin_d.range_infinite = 1'b0;
      end
      default: begin
        fin_d.range_value    = '0;
        fin_d.range_infinite = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin_load) begin
      fin_q <= fin_d;
    end
    if (cmd_i.out_load) begin
      out_q <= fin_q;
    end
  end

  assign out_data_o = out_q;

endmodule

FILE: rtl/ler_ctrl.sv
// Controller of the light effect range block: sequences probe ladder,
// unit-step search, squared sum and square root; owns both handshakes.
// Depends on ler_pkg; drives ler_dp through ler_pkg::cmd_t.
module ler_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  ler_pkg::stat_t stat_i,
  output ler_pkg::cmd_t  cmd_o
);

  ler_pkg::state_e state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic [2:0] idx_q, idx_d;
  logic       search_q, search_d;
  logic       out_valid_q;
  logic       out_free;
  logic       hit;

  assign out_free = !out_valid_q || !out_stall_i;
  assign hit = ler_pkg::probe_on_below(idx_q) ? stat_i.cmp_below : stat_i.cmp_above;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ler_pkg::ST_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      search_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
      search_q <= search_d;
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // next state
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    search_d = search_q;
    unique case (state_q)
      ler_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = ler_pkg::ST_DISPATCH;
      end
      ler_pkg::ST_DISPATCH: begin
        unique case (stat_i.kind)
          ler_pkg::KIND_POINT, ler_pkg::KIND_SPOT: begin
            idx_d    = ler_pkg::PROBE_FIRST;
            search_d = 1'b0;
            state_d  = ler_pkg::ST_EV_MUL1;
          end
          ler_pkg::KIND_BOX: begin
            cnt_d   = '0;
            state_d = ler_pkg::ST_SQ;
          end
          default: state_d = ler_pkg::ST_OUT;
        endcase
      end
      ler_pkg::ST_EV_MUL1: state_d = ler_pkg::ST_EV_MUL2;
      ler_pkg::ST_EV_MUL2: state_d = ler_pkg::ST_EV_ADD;
      ler_pkg::ST_EV_ADD:  state_d = ler_pkg::ST_EV_DECIDE;
      ler_pkg::ST_EV_DECIDE: begin
        priority if (search_q) begin
          state_d = stat_i.cmp_below ? ler_pkg::ST_OUT : ler_pkg::ST_CHECK;
        end else if (hit && idx_q == ler_pkg::PROBE_FIRST) begin
          state_d = ler_pkg::ST_OUT;
        end else if (hit || idx_q == ler_pkg::PROBE_LAST) begin
          search_d = 1'b1;
          state_d  = ler_pkg::ST_CHECK;
        end else begin
          idx_d   = idx_q + 3'd1;
          state_d = ler_pkg::ST_EV_MUL1;
        end
      end
      ler_pkg::ST_CHECK: begin
        state_d = stat_i.d_at_max ? ler_pkg::ST_OUT : ler_pkg::ST_EV_MUL1;
      end
      ler_pkg::ST_SQ: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == ler_pkg::SQ_LAST) state_d = ler_pkg::ST_ROOT_INIT;
      end
      ler_pkg::ST_ROOT_INIT: begin
        cnt_d   = '0;
        state_d = ler_pkg::ST_ROOT;
      end
      ler_pkg::ST_ROOT: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == ler_pkg::ROOT_LAST) state_d = ler_pkg::ST_ROOT_FIN;
      end
      ler_pkg::ST_ROOT_FIN: state_d = ler_pkg::ST_OUT;
      ler_pkg::ST_OUT: begin
        if (out_free) state_d = ler_pkg::ST_IDLE;
      end
      default: state_d = ler_pkg::ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = ler_pkg::MUL_Q_DD;
    cmd_o.fin_sel = ler_pkg::FIN_INF;
    unique case (state_q)
      ler_pkg::ST_IDLE: cmd_o.in_load = in_valid_i;
      ler_pkg::ST_DISPATCH: begin
        unique case (stat_i.kind)
          ler_pkg::KIND_POINT, ler_pkg::KIND_SPOT: begin
            cmd_o.d_load  = 1'b1;
            cmd_o.d_value = ler_pkg::probe_dist(ler_pkg::PROBE_FIRST);
          end
          ler_pkg::KIND_BOX: cmd_o.acc_clr = 1'b1;
          ler_pkg::KIND_SPHERE: begin
            cmd_o.fin_load = 1'b1;
            cmd_o.fin_sel  = ler_pkg::FIN_CONST;
          end
          default: cmd_o.fin_load = 1'b1;
        endcase
      end
      ler_pkg::ST_EV_MUL1: cmd_o.ev_mul1 = 1'b1;
      ler_pkg::ST_EV_MUL2: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.s1_en  = 1'b1;
      end
      ler_pkg::ST_EV_ADD: cmd_o.a_en = 1'b1;
      ler_pkg::ST_EV_DECIDE: begin
        priority if (search_q) begin
          if (stat_i.cmp_below) begin
            cmd_o.fin_load = 1'b1;
            cmd_o.fin_sel  = ler_pkg::FIN_DIST;
          end else begin
            cmd_o.d_inc = 1'b1;
          end
        end else if (hit && idx_q == ler_pkg::PROBE_FIRST) begin
          // still bright at the top rung: infinite
          cmd_o.fin_load = 1'b1;
        end else if (hit) begin
          cmd_o.d_load  = 1'b1;
          cmd_o.d_value = ler_pkg::probe_start(idx_q);
        end else if (idx_q == ler_pkg::PROBE_LAST) begin
          cmd_o.d_load  = 1'b1;
          cmd_o.d_value = '0;
        end else begin
          cmd_o.d_load  = 1'b1;
          cmd_o.d_value = ler_pkg::probe_dist(idx_q + 3'd1);
        end
      end
      ler_pkg::ST_CHECK: cmd_o.fin_load = stat_i.d_at_max;
      ler_pkg::ST_SQ: begin
        cmd_o.mul_en = (cnt_q != ler_pkg::SQ_LAST);
        cmd_o.acc_en = (cnt_q != 5'd0);
        unique case (cnt_q[1:0])
          2'd0:    cmd_o.mul_sel = ler_pkg::MUL_C;
          2'd1:    cmd_o.mul_sel = ler_pkg::MUL_L;
          default: cmd_o.mul_sel = ler_pkg::MUL_Q;
        endcase
      end
      ler_pkg::ST_ROOT_INIT: cmd_o.root_init = 1'b1;
      ler_pkg::ST_ROOT:      cmd_o.root_step = 1'b1;
      ler_pkg::ST_ROOT_FIN: begin
        cmd_o.fin_load = 1'b1;
        cmd_o.fin_sel  = ler_pkg::FIN_SQRT;
      end
      ler_pkg::ST_OUT: cmd_o.out_load = out_free;
      default: ;
    endcase
  end

  assign in_stall_o  = (state_q != ler_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/light_effect_range_top.sv
// Top level of the light effect range block: controller plus datapath.
// Depends on ler_pkg, ler_ctrl, ler_dp.
//
//   channel | direction | handshake                 | payload
//   in      | input     | in_valid_i / in_stall_o   | in_data_i  (ler_pkg::in_item_t)
//   out     | output    | out_valid_o / out_stall_i | out_data_o (ler_pkg::out_item_t)
//
// One item at a time. Point and spot lights: attenuation is evaluated in
// the shared multiply/add pipeline, up to 7 probe rungs, then unit steps.
// Ambient box: a squared sum, then the 32-step square root.
// Other kinds go straight to the output. Reset clears control state only.
// A held result stays in the output register while the next item is taken.
module light_effect_range_top #(
  parameter int MAX_DISTANCE  = 1000,
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ler_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ler_pkg::out_item_t out_data_o
);

  ler_pkg::cmd_t  cmd;
  ler_pkg::stat_t stat;

  ler_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ler_dp #(
    .MAX_DISTANCE  (MAX_DISTANCE),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

endmodule
